### rtl/i2cbb_pkg.sv
`timescale 1ns / 1ps
package i2cbb_pkg;

    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_STOP  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_SACK  = 3'd4;
    localparam logic [2:0] MODE_RACK  = 3'd5;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] write_data;
        logic       ack_out;
        logic [7:0] bus_levels;
    } cmd_t;

    // queue head as seen by the sequencer
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

### rtl/i2cbb_cmd_queue.sv
`timescale 1ns / 1ps
module i2cbb_cmd_queue
    import i2cbb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mode[2:0], write_data[10:3], ack_out[11], bus_levels[19:12]
    output q_head_t              head,
    input  logic                 pop
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       cmd_in;
    logic       push;
    logic       do_pop;

    assign cmd_in.mode       = s_tdata[2:0];
    assign cmd_in.write_data = s_tdata[10:3];
    assign cmd_in.ack_out    = s_tdata[11];
    assign cmd_in.bus_levels = s_tdata[19:12];

    assign s_tready = (count_reg != 2'd2);
    // unused mode codes cause no pin write and are dropped here
    assign push     = s_tvalid && s_tready && (cmd_in.mode <= MODE_RACK);
    assign do_pop   = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### rtl/i2cbb_pin_seq.sv
`timescale 1ns / 1ps
module i2cbb_pin_seq
    import i2cbb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_head_t              head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // scl_level[0], sda_level[1], sample_point[2], read_data[10:3]
    output logic                 m_tlast
);

    logic                 busy_reg, busy_next;
    logic [2:0]           mode_reg;
    logic [7:0]           shift_reg;
    logic                 ack_reg;
    logic [7:0]           bus_reg;
    logic [1:0]           ph_reg, ph_next;
    logic [2:0]           bit_reg, bit_next;
    logic                 scl_reg, sda_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    logic       advance, load;
    logic       is_scl, lvl, smp, fin;
    logic [7:0] rdata;
    logic       scl_new, sda_new;

    always_comb begin
        is_scl   = 1'b0;
        lvl      = 1'b1;
        smp      = 1'b0;
        fin      = 1'b0;
        rdata    = 8'd0;
        ph_next  = ph_reg + 2'd1;
        bit_next = bit_reg;
        unique case (mode_reg)
            MODE_START: begin
                is_scl = ph_reg[0];
                lvl    = ~ph_reg[1];
                fin    = (ph_reg == 2'd3);
            end
            MODE_STOP: begin
                is_scl = ~ph_reg[0];
                lvl    = ph_reg[1];
                fin    = (ph_reg == 2'd3);
            end
            MODE_WRITE: begin
                is_scl = (ph_reg != 2'd0);
                lvl    = (ph_reg == 2'd0) ? shift_reg[7] : (ph_reg == 2'd1);
                fin    = (ph_reg == 2'd2) && (bit_reg == 3'd7);
                if (ph_reg == 2'd2) begin
                    ph_next  = 2'd0;
                    bit_next = bit_reg + 3'd1;
                end
            end
            MODE_READ: begin
                is_scl = (ph_reg != 2'd0);
                lvl    = (ph_reg != 2'd2);
                smp    = (ph_reg == 2'd1);
                fin    = (ph_reg == 2'd2) && (bit_reg == 3'd7);
                rdata  = fin ? bus_reg : 8'd0;
                if (ph_reg == 2'd2) begin
                    ph_next  = 2'd1;
                    bit_next = bit_reg + 3'd1;
                end
            end
            MODE_SACK: begin
                is_scl = (ph_reg != 2'd0);
                lvl    = (ph_reg == 2'd0) ? ack_reg : (ph_reg == 2'd1);
                fin    = (ph_reg == 2'd2);
            end
            MODE_RACK: begin
                is_scl = (ph_reg != 2'd0);
                lvl    = (ph_reg != 2'd2);
                smp    = (ph_reg == 2'd1);
                fin    = (ph_reg == 2'd2);
                rdata  = fin ? {7'd0, bus_reg[7]} : 8'd0;
            end
            default: begin
                fin = 1'b1;
            end
        endcase
    end

    assign advance = busy_reg && (!m_tvalid_reg || m_tready);
    assign load    = head.valid && (!busy_reg || (advance && fin));
    assign pop     = load;
    assign scl_new = is_scl ? lvl : scl_reg;
    assign sda_new = is_scl ? sda_reg : lvl;

    always_comb begin
        busy_next = busy_reg;
        if (load) begin
            busy_next = 1'b1;
        end else if (advance && fin) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            ph_reg       <= 2'd0;
            bit_reg      <= 3'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (load) begin
                ph_reg  <= 2'd0;
                bit_reg <= 3'd0;
            end else if (advance) begin
                ph_reg  <= ph_next;
                bit_reg <= bit_next;
            end
            if (advance) begin
                scl_reg      <= scl_new;
                sda_reg      <= sda_new;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mode_reg  <= head.cmd.mode;
            shift_reg <= head.cmd.write_data;
            ack_reg   <= head.cmd.ack_out;
            bus_reg   <= head.cmd.bus_levels;
        end else if (advance && (mode_reg == MODE_WRITE) && (ph_reg == 2'd2)) begin
            shift_reg <= {shift_reg[6:0], 1'b0};
        end
        if (advance) begin
            m_tdata_reg <= {5'd0, rdata, smp, sda_new, scl_new};
            m_tlast_reg <= fin;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/i2c_bitbang_master_sequencer.sv
`timescale 1ns / 1ps
// Bit-level I2C master: each input item is one bus command and every pin write comes out as one
// result item carrying both pin levels. One result leaves per clock while the output is taken
// and a command is in hand; a command gives 4 (start, stop), 24 (write byte), 17 (read byte) or
// 3 (send/read ack) results, and when the queue already holds the next command, it is loaded as
// the previous one's last result is registered, with no gap. A two-entry command queue in front
// lets new commands be taken while a run is still going. Mode codes 6 and 7 produce nothing.
module i2c_bitbang_master_sequencer
    import i2cbb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mode[2:0], write_data[10:3], ack_out[11], bus_levels[19:12]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // scl_level[0], sda_level[1], sample_point[2], read_data[10:3]
    output logic                 m_tlast
);

    q_head_t head;
    logic    pop;

    i2cbb_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    i2cbb_pin_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/i2cbb_checker.sv
`timescale 1ns / 1ps
module i2cbb_checker
    import i2cbb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_sample_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[0] && !m_tlast)
        else $error("sample point outside SCL high or on last result");

    a_data_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[10:3] == 8'd0)
        else $error("read data before last result");

    a_last_scl_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !(m_tdata[0] && m_tdata[1]) |-> !m_tdata[0])
        else $error("run ended with SCL high outside a stop");

endmodule

bind i2c_bitbang_master_sequencer i2cbb_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### sim/i2c_pin_checker.sv
`timescale 1ns / 1ps
module i2c_pin_checker
    import i2cbb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mode[2:0], write_data[10:3], ack_out[11], bus_levels[19:12]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // scl_level[0], sda_level[1], sample_point[2], read_data[10:3]
    input  logic                 m_tlast,
    output int                   mismatch_count,
    output int                   pin_writes_pending
);

    localparam logic PIN_SCL = 1'b1;
    localparam logic PIN_SDA = 1'b0;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       sample;
        logic [7:0] rdata;
        logic       fin;
    } pin_write_t;

    pin_write_t pin_writes_due[$];
    logic       bus_scl;
    logic       bus_sda;

    function automatic void drive_pin(input logic pin, input logic level, input logic sample,
                                      input logic [7:0] rdata, input logic fin);
        pin_write_t pw;
        if (pin == PIN_SCL) begin
            bus_scl = level;
        end else begin
            bus_sda = level;
        end
        pw.scl    = bus_scl;
        pw.sda    = bus_sda;
        pw.sample = sample;
        pw.rdata  = rdata;
        pw.fin    = fin;
        pin_writes_due.push_back(pw);
    endfunction

    function automatic void predict_pin_writes(input logic [S_TDATA_W-1:0] item);
        logic [2:0] mode;
        logic [7:0] wdata;
        logic       ack;
        logic [7:0] bus;
        mode  = item[2:0];
        wdata = item[10:3];
        ack   = item[11];
        bus   = item[19:12];
        case (mode)
            MODE_START: begin
                drive_pin(PIN_SDA, 1'b1, 1'b0, 8'h00, 1'b0);
                drive_pin(PIN_SCL, 1'b1, 1'b0, 8'h00, 1'b0);
                drive_pin(PIN_SDA, 1'b0, 1'b0, 8'h00, 1'b0);
                drive_pin(PIN_SCL, 1'b0, 1'b0, 8'h00, 1'b1);
            end
            MODE_STOP: begin
                drive_pin(PIN_SCL, 1'b0, 1'b0, 8'h00, 1'b0);
                drive_pin(PIN_SDA, 1'b0, 1'b0, 8'h00, 1'b0);
                drive_pin(PIN_SCL, 1'b1, 1'b0, 8'h00, 1'b0);
                drive_pin(PIN_SDA, 1'b1, 1'b0, 8'h00, 1'b1);
            end
            MODE_WRITE: begin
                for (int i = 7; i >= 0; i--) begin
                    drive_pin(PIN_SDA, wdata[i], 1'b0, 8'h00, 1'b0);
                    drive_pin(PIN_SCL, 1'b1, 1'b0, 8'h00, 1'b0);
                    drive_pin(PIN_SCL, 1'b0, 1'b0, 8'h00, i == 0);
                end
            end
            MODE_READ: begin
                drive_pin(PIN_SDA, 1'b1, 1'b0, 8'h00, 1'b0);
                for (int i = 0; i < 8; i++) begin
                    drive_pin(PIN_SCL, 1'b1, 1'b1, 8'h00, 1'b0);
                    drive_pin(PIN_SCL, 1'b0, 1'b0, (i == 7) ? bus : 8'h00, i == 7);
                end
            end
            MODE_SACK: begin
                drive_pin(PIN_SDA, ack, 1'b0, 8'h00, 1'b0);
                drive_pin(PIN_SCL, 1'b1, 1'b0, 8'h00, 1'b0);
                drive_pin(PIN_SCL, 1'b0, 1'b0, 8'h00, 1'b1);
            end
            MODE_RACK: begin
                drive_pin(PIN_SDA, 1'b1, 1'b0, 8'h00, 1'b0);
                drive_pin(PIN_SCL, 1'b1, 1'b1, 8'h00, 1'b0);
                drive_pin(PIN_SCL, 1'b0, 1'b0, {7'd0, bus[7]}, 1'b1);
            end
            default: begin
                // spare codes: no pin activity
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        pin_write_t got;
        pin_write_t want;
        if (!aresetn) begin
            pin_writes_due.delete();
            bus_scl = 1'b1;
            bus_sda = 1'b1;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pin_writes(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[10:3], m_tlast};
                if (pin_writes_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected item: expected none, got scl=%b sda=%b sample=%b data=%02h last=%b",
                             $time, got.scl, got.sda, got.sample, got.rdata, got.fin);
                end else begin
                    want = pin_writes_due.pop_front();
                    if (got.scl !== want.scl || got.sda !== want.sda ||
                        got.sample !== want.sample || got.rdata !== want.rdata ||
                        got.fin !== want.fin) begin
                        mismatch_count++;
                        $display("%0t mismatch: expected scl=%b sda=%b sample=%b data=%02h last=%b",
                                 $time, want.scl, want.sda, want.sample, want.rdata, want.fin);
                        $display("%0t          actual   scl=%b sda=%b sample=%b data=%02h last=%b",
                                 $time, got.scl, got.sda, got.sample, got.rdata, got.fin);
                    end
                end
            end
        end
        pin_writes_pending = pin_writes_due.size();
    end

endmodule

### sim/tb_i2c_bitbang_master_sequencer.sv
`timescale 1ns / 1ps
module tb_i2c_bitbang_master_sequencer;
    import i2cbb_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int         RANDOM_ITEMS  = 125;
    localparam int         DRAIN_CYCLES  = 64;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    int                   mismatch_count;
    int                   pin_writes_pending;
    int                   burst_left;
    int                   items_sent;

    i2c_bitbang_master_sequencer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    i2c_pin_checker i_pin_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tlast            (m_tlast),
        .mismatch_count     (mismatch_count),
        .pin_writes_pending (pin_writes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: ready style rotates through four patterns
    initial begin
        int cycle;
        cycle    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            case ((cycle / 300) % 4)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 1) == 1);
                2: m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = ((cycle % 7) < 3);
            endcase
            cycle++;
        end
    end

    task automatic send_cmd(input logic [2:0] mode, input logic [7:0] wdata, input logic ack,
                            input logic [7:0] bus);
        s_tdata  = {4'd0, bus, ack, wdata, mode};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
                @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 5);
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pin_writes_pending != 0) @(negedge aclk);
    endtask

    initial begin
        logic rd;
        int   nbytes;
        bit   paused;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        items_sent = 0;
        burst_left = 4;
        paused     = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_cmd(MODE_START, 8'hFF, 1'b1, 8'hFF);
        send_cmd(MODE_WRITE, 8'h00, 1'b0, 8'h00);
        send_cmd(MODE_WRITE, 8'hFF, 1'b1, 8'hFF);
        send_cmd(MODE_RACK, 8'h00, 1'b0, 8'h00);
        send_cmd(MODE_RACK, 8'hFF, 1'b1, 8'hFF);
        send_cmd(MODE_SACK, 8'h00, 1'b0, 8'h00);
        send_cmd(MODE_SACK, 8'hFF, 1'b1, 8'hFF);
        send_cmd(MODE_READ, 8'h00, 1'b0, 8'hFF);
        send_cmd(MODE_READ, 8'hFF, 1'b1, 8'h00);
        send_cmd(MODE_READ, 8'h3C, 1'b0, 8'hA5);
        send_cmd(MODE_WRITE, 8'h5A, 1'b0, 8'h00);
        send_cmd(MODE_SPARE_LO, 8'hFF, 1'b1, 8'hFF);
        send_cmd(MODE_SPARE_HI, 8'h00, 1'b0, 8'h00);
        send_cmd(MODE_STOP, 8'h00, 1'b0, 8'h00);
        send_cmd(MODE_STOP, 8'hFF, 1'b1, 8'hFF);
        send_cmd(MODE_START, 8'h00, 1'b0, 8'h00);
        send_cmd(MODE_START, 8'h00, 1'b0, 8'h00);
        send_cmd(MODE_WRITE, 8'hA1, 1'b1, 8'h7F);
        send_cmd(MODE_RACK, 8'h00, 1'b0, 8'h7F);
        send_cmd(MODE_SACK, 8'h00, 1'b1, 8'h00);
        send_cmd(MODE_STOP, 8'h00, 1'b0, 8'h00);
        wait_drained();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 6) == 0) begin
                send_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 8'($urandom));
            end else begin
                rd = 1'($urandom);
                send_cmd(MODE_START, 8'($urandom), 1'($urandom), 8'($urandom));
                send_cmd(MODE_WRITE, {7'($urandom), rd}, 1'($urandom), 8'($urandom));
                send_cmd(MODE_RACK, 8'($urandom), 1'($urandom),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)});
                nbytes = $urandom_range(1, 4);
                for (int i = 0; i < nbytes; i++) begin
                    if (rd) begin
                        send_cmd(MODE_READ, 8'($urandom), 1'($urandom), 8'($urandom));
                        send_cmd(MODE_SACK, 8'($urandom),
                                 ($urandom_range(0, 7) == 0) ? 1'($urandom) : (i == nbytes - 1),
                                 8'($urandom));
                    end else begin
                        send_cmd(MODE_WRITE, 8'($urandom), 1'($urandom), 8'($urandom));
                        send_cmd(MODE_RACK, 8'($urandom), 1'($urandom), 8'($urandom));
                    end
                end
                if ($urandom_range(0, 4) != 0) begin
                    send_cmd(MODE_STOP, 8'($urandom), 1'($urandom), 8'($urandom));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pin_writes_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
